// ----- rtl/tlua_pkg.sv -----
// ----------------------------------------------------------------------------
// tlua_pkg
// Shared types and constants for the taint label union allocator.
// ----------------------------------------------------------------------------
package tlua_pkg;

    localparam int unsigned LABEL_BITS      = 16;
    localparam int unsigned DECAY_BITS      = 16;
    localparam int unsigned OFFSET_BITS     = 31;
    localparam int unsigned MAX_LABEL_COUNT = 65535;
    localparam int unsigned MEMO_DEPTH      = 1024;
    localparam int unsigned MEMO_IDX_BITS   = $clog2(MEMO_DEPTH);
    localparam int unsigned NODE_DEPTH      = 2 ** LABEL_BITS;
    localparam int unsigned KEY_BITS        = 2 * LABEL_BITS;
    localparam int unsigned NODE_BITS       = KEY_BITS + DECAY_BITS;
    localparam int unsigned MEMO_BITS       = KEY_BITS + LABEL_BITS;

    localparam logic [DECAY_BITS-1:0] CANON_DECAY_RESET = DECAY_BITS'(64);

    typedef enum logic [1:0] {
        OP_CANON = 2'd0,
        OP_UNION = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_MEMO_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_LO,
        S_RD_HI,
        S_SCAN,
        S_RD_NODE,
        S_FINISH
    } t_state;

endpackage

// ----- rtl/tlua_if.sv -----
// ----------------------------------------------------------------------------
// tlua_req_if / tlua_rsp_if
// Valid/ready channels carrying one request word and one response word.
// ----------------------------------------------------------------------------
interface tlua_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          op;
    logic [tlua_pkg::LABEL_BITS-1:0]     label_a;
    logic [tlua_pkg::LABEL_BITS-1:0]     label_b;
    logic [tlua_pkg::OFFSET_BITS-1:0]    byte_offset;

    modport source (output valid, op, label_a, label_b, byte_offset, input ready);
    modport sink   (input valid, op, label_a, label_b, byte_offset, output ready);
endinterface

interface tlua_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [tlua_pkg::LABEL_BITS-1:0]     result_label;
    logic [tlua_pkg::OFFSET_BITS-1:0]    offset_echo;
    logic [tlua_pkg::LABEL_BITS-1:0]     parent_one;
    logic [tlua_pkg::LABEL_BITS-1:0]     parent_two;
    logic [tlua_pkg::DECAY_BITS-1:0]     node_decay;
    logic [1:0]                          status;

    modport source (output valid, result_label, offset_echo, parent_one, parent_two,
                    node_decay, status, input ready);
    modport sink   (input valid, result_label, offset_echo, parent_one, parent_two,
                    node_decay, status, output ready);
endinterface

// ----- rtl/tlua_ram.sv -----
// ----------------------------------------------------------------------------
// tlua_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tlua_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];   // holds when not reading
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/taint_label_union_allocator_top.sv -----
// ----------------------------------------------------------------------------
// taint_label_union_allocator_top
// Taint label allocator with a node store and a union memo table.
// ----------------------------------------------------------------------------
// Hands out taint labels from a counter starting at 1 (label 0 = untainted).
// op 0 makes a canonical label, op 1 unions two labels through a memo table,
// op 2 reads a node back. Node parents and decay live in one 64K-entry RAM;
// memo pairs live in a 1024-entry RAM filled in order, so a fill count marks
// the valid entries and no clearing pass is needed after reset. A full union
// scans the memo entries up to the fill count (at most 1024), one memo RAM
// read per cycle, and stops at the first entry whose key matches.
// A new word is taken only in idle; a finished response may still wait in
// the output register while the next word is accepted.
// ----------------------------------------------------------------------------
module taint_label_union_allocator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tlua_req_if.sink                          i_req,
    tlua_rsp_if.source                        o_rsp,
    input  logic                              i_cfg_we,
    input  logic [tlua_pkg::DECAY_BITS-1:0]   i_cfg_wdata
);

    localparam int unsigned LB = tlua_pkg::LABEL_BITS;
    localparam int unsigned DB = tlua_pkg::DECAY_BITS;
    localparam int unsigned MI = tlua_pkg::MEMO_IDX_BITS;

    // control state
    tlua_pkg::t_state r_state, n_state;
    logic [LB-1:0]    r_nfl;              // next free label
    logic [MI:0]      r_cnt;              // memo fill count
    logic [DB-1:0]    r_cdecay;
    logic             r_ovalid;
    logic             r_hit;

    // request latch
    tlua_pkg::t_op                  r_op;
    logic [LB-1:0]                  r_la, r_lb, r_lo, r_hi;
    logic [tlua_pkg::OFFSET_BITS-1:0] r_off;
    logic [DB-1:0]                  r_dlo, r_dhi;
    logic [MI-1:0]                  r_idx;

    // output register
    logic [LB-1:0]                  r_res, r_p1, r_p2;
    logic [tlua_pkg::OFFSET_BITS-1:0] r_echo;
    logic [DB-1:0]                  r_dec;
    tlua_pkg::t_status              r_stat;

    // RAM ports
    logic                           node_we, node_re, memo_we, memo_re;
    logic [LB-1:0]                  node_raddr, node_waddr;
    logic [tlua_pkg::NODE_BITS-1:0] node_wdata, node_rdata;
    logic [MI-1:0]                  memo_raddr;
    logic [tlua_pkg::MEMO_BITS-1:0] memo_wdata, memo_rdata;

    logic                           accept, fin_go, trivial, key_match, scan_last, exhausted;
    logic [LB-1:0]                  in_lo, in_hi;
    logic [DB:0]                    dsum;
    logic [DB-1:0]                  dnew;

    // finish results
    logic [LB-1:0]                  f_res, f_p1, f_p2;
    logic [tlua_pkg::OFFSET_BITS-1:0] f_echo;
    logic [DB-1:0]                  f_dec;
    tlua_pkg::t_status              f_stat;
    logic                           f_take;   // label consumed
    logic                           f_memo;   // pair memoised

    tlua_ram #(.WIDTH(tlua_pkg::NODE_BITS), .DEPTH(tlua_pkg::NODE_DEPTH)) u_node_ram (
        .i_clk  (i_clk),
        .i_we   (node_we),
        .i_waddr(node_waddr),
        .i_wdata(node_wdata),
        .i_re   (node_re),
        .i_raddr(node_raddr),
        .o_rdata(node_rdata)
    );

    tlua_ram #(.WIDTH(tlua_pkg::MEMO_BITS), .DEPTH(tlua_pkg::MEMO_DEPTH)) u_memo_ram (
        .i_clk  (i_clk),
        .i_we   (memo_we),
        .i_waddr(r_cnt[MI-1:0]),
        .i_wdata(memo_wdata),
        .i_re   (memo_re),
        .i_raddr(memo_raddr),
        .o_rdata(memo_rdata)
    );

    assign i_req.ready = (r_state == tlua_pkg::S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign fin_go      = (r_state == tlua_pkg::S_FINISH) && (!r_ovalid || o_rsp.ready);

    assign in_lo   = (i_req.label_a < i_req.label_b) ? i_req.label_a : i_req.label_b;
    assign in_hi   = (i_req.label_a < i_req.label_b) ? i_req.label_b : i_req.label_a;
    assign trivial = (i_req.label_a == '0) || (i_req.label_b == '0);

    assign key_match = (memo_rdata[tlua_pkg::MEMO_BITS-1:LB] == {r_lo, r_hi});
    assign scan_last = ({1'b0, r_idx} + (MI+1)'(1)) == r_cnt;
    assign exhausted = r_nfl >= LB'(tlua_pkg::MAX_LABEL_COUNT);
    assign dsum      = {1'b0, r_dlo} + {1'b0, r_dhi};
    assign dnew      = DB'(dsum >> 2);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tlua_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (tlua_pkg::t_op'(i_req.op))
                        tlua_pkg::OP_UNION: n_state = trivial ? tlua_pkg::S_FINISH
                                                              : tlua_pkg::S_RD_LO;
                        tlua_pkg::OP_READ:  n_state = tlua_pkg::S_RD_NODE;
                        default:            n_state = tlua_pkg::S_FINISH;
                    endcase
                end
            end
            tlua_pkg::S_RD_LO:   n_state = tlua_pkg::S_RD_HI;
            tlua_pkg::S_RD_HI:   n_state = (r_cnt == '0) ? tlua_pkg::S_FINISH
                                                         : tlua_pkg::S_SCAN;
            tlua_pkg::S_SCAN:    n_state = (key_match || scan_last) ? tlua_pkg::S_FINISH
                                                                    : tlua_pkg::S_SCAN;
            tlua_pkg::S_RD_NODE: n_state = tlua_pkg::S_FINISH;
            tlua_pkg::S_FINISH:  n_state = fin_go ? tlua_pkg::S_IDLE : tlua_pkg::S_FINISH;
            default:             n_state = tlua_pkg::S_IDLE;
        endcase
    end

    // RAM read control
    always_comb begin
        node_re    = 1'b0;
        node_raddr = r_hi;
        memo_re    = 1'b0;
        memo_raddr = r_idx + MI'(1);
        unique case (r_state)
            tlua_pkg::S_IDLE: begin
                node_raddr = (tlua_pkg::t_op'(i_req.op) == tlua_pkg::OP_READ) ? i_req.label_a
                                                                                : in_lo;
                node_re    = accept && ((tlua_pkg::t_op'(i_req.op) == tlua_pkg::OP_READ) ||
                             ((tlua_pkg::t_op'(i_req.op) == tlua_pkg::OP_UNION) && !trivial));
            end
            tlua_pkg::S_RD_LO: node_re = 1'b1;
            tlua_pkg::S_RD_HI: begin
                memo_re    = (r_cnt != '0);
                memo_raddr = '0;
            end
            tlua_pkg::S_SCAN:  memo_re = !key_match && !scan_last;
            default: ;
        endcase
    end

    // finish datapath
    always_comb begin
        f_res  = '0;
        f_echo = '0;
        f_p1   = '0;
        f_p2   = '0;
        f_dec  = '0;
        f_stat = tlua_pkg::ST_OK;
        f_take = 1'b0;
        f_memo = 1'b0;
        node_wdata = {{tlua_pkg::KEY_BITS{1'b0}}, r_cdecay};
        unique case (r_op)
            tlua_pkg::OP_CANON: begin
                if (exhausted) begin
                    f_stat = tlua_pkg::ST_EXHAUSTED;
                end else begin
                    f_take = 1'b1;
                    f_res  = r_nfl;
                    f_echo = r_off;
                    f_dec  = r_cdecay;
                end
            end
            tlua_pkg::OP_UNION: begin
                node_wdata = {r_lo, r_hi, dnew};
                priority if (r_la == '0) begin
                    f_res = r_lb;
                end else if (r_lb == '0) begin
                    f_res = r_la;
                end else if (r_hit) begin
                    f_res = memo_rdata[LB-1:0];
                end else if (dnew == '0) begin
                    f_res = '0;
                end else if (exhausted) begin
                    f_stat = tlua_pkg::ST_EXHAUSTED;
                end else begin
                    f_take = 1'b1;
                    f_res  = r_nfl;
                    f_dec  = dnew;
                    if (r_cnt == (MI+1)'(tlua_pkg::MEMO_DEPTH)) begin
                        f_stat = tlua_pkg::ST_MEMO_FULL;
                    end else begin
                        f_memo = 1'b1;
                    end
                end
            end
            tlua_pkg::OP_READ: begin
                f_res = r_la;
                f_p1  = node_rdata[tlua_pkg::NODE_BITS-1 -: LB];
                f_p2  = node_rdata[DB +: LB];
                f_dec = node_rdata[DB-1:0];
            end
            tlua_pkg::OP_NONE: ;
            default: ;
        endcase
    end

    assign node_we    = fin_go && f_take;
    assign node_waddr = r_nfl;
    assign memo_we    = fin_go && f_memo;
    assign memo_wdata = {r_lo, r_hi, r_nfl};

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tlua_pkg::S_IDLE;
            r_nfl    <= LB'(1);
            r_cnt    <= '0;
            r_cdecay <= tlua_pkg::CANON_DECAY_RESET;
            r_ovalid <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cdecay <= i_cfg_wdata;
            end
            if (node_we) begin
                r_nfl <= r_nfl + LB'(1);
            end
            if (memo_we) begin
                r_cnt <= r_cnt + (MI+1)'(1);
            end
            if (accept) begin
                r_hit <= 1'b0;
            end else if (r_state == tlua_pkg::S_SCAN && key_match) begin
                r_hit <= 1'b1;
            end
            if (fin_go) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= tlua_pkg::t_op'(i_req.op);
            r_la  <= i_req.label_a;
            r_lb  <= i_req.label_b;
            r_lo  <= in_lo;
            r_hi  <= in_hi;
            r_off <= i_req.byte_offset;
        end
        if (r_state == tlua_pkg::S_RD_LO) begin
            r_dlo <= node_rdata[DB-1:0];
        end
        if (r_state == tlua_pkg::S_RD_HI) begin
            r_dhi <= node_rdata[DB-1:0];
            r_idx <= '0;
        end else if (r_state == tlua_pkg::S_SCAN && memo_re) begin
            r_idx <= r_idx + MI'(1);
        end
        if (fin_go) begin
            r_res  <= f_res;
            r_echo <= f_echo;
            r_p1   <= f_p1;
            r_p2   <= f_p2;
            r_dec  <= f_dec;
            r_stat <= f_stat;
        end
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.result_label = r_res;
    assign o_rsp.offset_echo  = r_echo;
    assign o_rsp.parent_one   = r_p1;
    assign o_rsp.parent_two   = r_p2;
    assign o_rsp.node_decay   = r_dec;
    assign o_rsp.status       = r_stat;

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the taint label union allocator. Every accepted request word is run
// through a label/memo predictor kept in a scoreboard, and each response word
// is compared field by field against the oldest expected word. The stimulus
// covers the canonical decay setting, union hits and misses, zero decay and a
// full memo table, with hits found at the first pair of the fill and the last entry.
// ----------------------------------------------------------------------------
module testbench;
    import tlua_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_WORDS   = 60;
    localparam int TAIL_WORDS     = 20;

    typedef struct packed {
        logic [LABEL_BITS-1:0]  label;
        logic [OFFSET_BITS-1:0] offset;
        logic [LABEL_BITS-1:0]  par_one;
        logic [LABEL_BITS-1:0]  par_two;
        logic [DECAY_BITS-1:0]  decay;
        logic [1:0]             status;
    } t_rsp_word;

    // Label allocator predictor plus queue of expected response words.
    class label_scoreboard;
        bit [KEY_BITS-1:0]   parent_mem [NODE_DEPTH];
        bit [DECAY_BITS-1:0] decay_mem  [NODE_DEPTH];
        bit [LABEL_BITS-1:0] memo [bit [KEY_BITS-1:0]];
        int unsigned         memo_used;
        int unsigned         next_free;
        bit [DECAY_BITS-1:0] canon_decay;
        t_rsp_word           expected_q [$];
        int                  mismatches;

        function new();
            next_free   = 1;
            memo_used   = 0;
            canon_decay = CANON_DECAY_RESET;
            mismatches  = 0;
        endfunction

        // Returns 0 once the label space is used up.
        function int unsigned grab_label();
            int unsigned lab;
            lab = next_free;
            if (lab >= MAX_LABEL_COUNT) return 0;
            next_free = lab + 1;
            return lab;
        endfunction

        function void note_request(t_op op, logic [LABEL_BITS-1:0] la,
                                   logic [LABEL_BITS-1:0] lb,
                                   logic [OFFSET_BITS-1:0] off);
            t_rsp_word           w;
            int unsigned         lab;
            bit [LABEL_BITS-1:0] lo, hi;
            bit [KEY_BITS-1:0]   key;
            int unsigned         d;
            w = '0;
            case (op)
                OP_CANON: begin
                    lab = grab_label();
                    if (lab == 0) begin
                        w.status = ST_EXHAUSTED;
                    end else begin
                        parent_mem[lab] = '0;
                        decay_mem[lab]  = canon_decay;
                        w.label  = LABEL_BITS'(lab);
                        w.offset = off;
                        w.decay  = canon_decay;
                    end
                end
                OP_UNION: begin
                    if (la == 0) begin
                        w.label = lb;
                    end else if (lb == 0) begin
                        w.label = la;
                    end else begin
                        lo  = (la < lb) ? la : lb;
                        hi  = (la < lb) ? lb : la;
                        key = {lo, hi};
                        if (memo.exists(key)) begin
                            w.label = memo[key];
                        end else begin
                            d = (int'(decay_mem[lo]) + int'(decay_mem[hi])) / 4;
                            if (d != 0) begin
                                lab = grab_label();
                                if (lab == 0) begin
                                    w.status = ST_EXHAUSTED;
                                end else begin
                                    parent_mem[lab] = key;
                                    decay_mem[lab]  = DECAY_BITS'(d);
                                    w.label = LABEL_BITS'(lab);
                                    w.decay = DECAY_BITS'(d);
                                    if (memo_used >= MEMO_DEPTH) begin
                                        w.status = ST_MEMO_FULL;
                                    end else begin
                                        memo[key] = LABEL_BITS'(lab);
                                        memo_used++;
                                    end
                                end
                            end
                        end
                    end
                end
                OP_READ: begin
                    w.label   = la;
                    w.par_one = parent_mem[la][KEY_BITS-1:LABEL_BITS];
                    w.par_two = parent_mem[la][LABEL_BITS-1:0];
                    w.decay   = decay_mem[la];
                end
                default: ;
            endcase
            expected_q.insert(expected_q.size(), w);
        endfunction

        function void check_response(t_rsp_word got);
            t_rsp_word want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response word %p", got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            cfg_we;
    logic [DECAY_BITS-1:0] cfg_wdata;

    tlua_req_if req_if ();
    tlua_rsp_if rsp_if ();

    taint_label_union_allocator_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if.sink),
        .o_rsp       (rsp_if.source),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    label_scoreboard sb;
    int              hold_asked   = 0;   // long response stalls requested
    int              hold_done    = 0;   // long response stalls served
    int              quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Response ready: random stalls, plus one long hold-off on request.
    initial begin
        rsp_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_done != hold_asked) begin
                rsp_if.ready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_done++;
            end else if (!rsp_if.ready) begin
                rsp_if.ready = 1'b1;
            end else begin
                int g;
                g = gap_len();
                if (g > 0) begin
                    rsp_if.ready = 1'b0;
                    repeat (g - 1) @(negedge i_clk);
                end
            end
        end
    end

    // Both handshakes sampled at the rising edge; requests noted first.
    always @(posedge i_clk) begin
        t_rsp_word got;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                sb.note_request(t_op'(req_if.op), req_if.label_a, req_if.label_b,
                                req_if.byte_offset);
            if (rsp_if.valid && rsp_if.ready) begin
                got.label   = rsp_if.result_label;
                got.offset  = rsp_if.offset_echo;
                got.par_one = rsp_if.parent_one;
                got.par_two = rsp_if.parent_two;
                got.decay   = rsp_if.node_decay;
                got.status  = rsp_if.status;
                sb.check_response(got);
            end
            // watchdog: count cycles without any accepted word
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Offers one request word; returns at the falling edge after acceptance.
    task automatic send_word(t_op op, logic [LABEL_BITS-1:0] la,
                             logic [LABEL_BITS-1:0] lb, logic [OFFSET_BITS-1:0] off);
        int g;
        g = gap_len();
        if (g > 0) begin
            req_if.valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        req_if.valid       = 1'b1;
        req_if.op          = op;
        req_if.label_a     = la;
        req_if.label_b     = lb;
        req_if.byte_offset = off;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    function automatic logic [OFFSET_BITS-1:0] rand_offset();
        return OFFSET_BITS'($urandom);
    endfunction

    // Register writes happen only once everything in flight has come back.
    task automatic set_canon_decay(logic [DECAY_BITS-1:0] value);
        req_if.valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge i_clk);
        cfg_we    = 1'b0;
        sb.canon_decay = value;
    endtask

    // An allocated label near the top of the counter, so unions often hit.
    function automatic logic [LABEL_BITS-1:0] recent_label();
        int unsigned lo;
        lo = (sb.next_free > 40) ? sb.next_free - 40 : 1;
        return LABEL_BITS'($urandom_range(sb.next_free - 1, lo));
    endfunction

    task automatic random_word();
        int r;
        logic [LABEL_BITS-1:0] a, b;
        r = $urandom_range(99);
        if (r < 30) begin
            send_word(OP_CANON, LABEL_BITS'($urandom), LABEL_BITS'($urandom),
                      rand_offset());
        end else if (r < 75) begin
            a = recent_label();
            b = recent_label();
            // pass-through with any label on the other side
            if (r < 80 && $urandom_range(9) == 0) a = 0;
            if ($urandom_range(14) == 0) begin
                a = 0;
                b = LABEL_BITS'($urandom);
            end else if ($urandom_range(14) == 0) begin
                a = LABEL_BITS'($urandom);
                b = 0;
            end
            send_word(OP_UNION, a, b, rand_offset());
        end else if (r < 95) begin
            send_word(OP_READ, LABEL_BITS'($urandom_range(sb.next_free - 1, 1)),
                      LABEL_BITS'($urandom), rand_offset());
        end else begin
            send_word(OP_NONE, LABEL_BITS'($urandom), LABEL_BITS'($urandom),
                      rand_offset());
        end
    endtask

    // Random words under a fresh decay setting, optionally with one long stall.
    task automatic random_burst(int count, bit with_hold);
        set_canon_decay(($urandom_range(3) == 0) ? 16'hFFFF :
                        DECAY_BITS'($urandom_range(16'hFFFF, 1)));
        for (int n = 0; n < count; n++) begin
            if (with_hold && n == count / 2) hold_asked++;
            random_word();
        end
    endtask

    initial begin
        logic [LABEL_BITS-1:0] p, q, prev, fresh;
        sb           = new();
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        req_if.valid = 1'b0;
        req_if.op    = OP_NONE;
        req_if.label_a     = '0;
        req_if.label_b     = '0;
        req_if.byte_offset = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed words at the reset decay: labels 1..3 canonical.
        send_word(OP_CANON, '0, '0, '0);
        send_word(OP_CANON, '1, '1, '1);
        send_word(OP_CANON, '0, '1, 31'h2AAA_5555);
        send_word(OP_UNION, 16'd1, 16'd2, '0);   // miss, new label 4
        send_word(OP_UNION, 16'd2, 16'd1, '0);   // same pair reversed: hit
        send_word(OP_UNION, 16'd3, 16'd3, '0);   // equal labels
        send_word(OP_UNION, 16'd0, 16'hFFFF, '0); // zero label passes other one
        send_word(OP_UNION, 16'hFFFF, 16'd0, '0);
        send_word(OP_UNION, 16'd0, 16'd0, '0);
        send_word(OP_READ, 16'd4, '1, '1);
        send_word(OP_READ, 16'd1, '0, '0);
        send_word(OP_NONE, '1, '1, '1);
        send_word(OP_UNION, 16'd4, 16'd5, '0);   // decay chain: label 5 from 3,3

        // Smallest decay: union of two such labels gives zero decay, label 0.
        set_canon_decay(16'd1);
        send_word(OP_CANON, '0, '0, 31'd7);
        send_word(OP_CANON, '0, '0, 31'd8);
        p = LABEL_BITS'(sb.next_free - 1);
        send_word(OP_UNION, p, p - 16'd1, '0);
        send_word(OP_READ, p, '0, '0);

        set_canon_decay(16'hFFFF);
        send_word(OP_CANON, '0, '0, '1);
        send_word(OP_UNION, LABEL_BITS'(sb.next_free - 1), 16'd1, '0);

        // Random words with one long response stall in the middle.
        random_burst(RANDOM_WORDS, 1'b1);

        // Fill the memo table: each new union label is paired with one anchor,
        // so every pair is fresh and its decay settles well above zero.
        set_canon_decay(16'hFFFF);
        send_word(OP_CANON, '0, '0, rand_offset());
        q    = LABEL_BITS'(sb.next_free - 1);
        prev = q;
        while (sb.memo_used < MEMO_DEPTH) begin
            p     = prev;
            fresh = LABEL_BITS'(sb.next_free);
            if ($urandom_range(1) == 0)
                send_word(OP_UNION, prev, q, '0);
            else
                send_word(OP_UNION, q, prev, '0);
            prev = fresh;
        end

        // Full table: misses still allocate, hits found at first fill pair and last entry.
        for (int n = 0; n < 3; n++) begin
            fresh = LABEL_BITS'(sb.next_free);
            send_word(OP_UNION, prev, q, rand_offset());
            prev = fresh;
        end
        send_word(OP_UNION, q, q, '0);
        send_word(OP_UNION, q, p, '0);
        send_word(OP_READ, prev, '0, '0);

        random_burst(TAIL_WORDS, 1'b0);

        req_if.valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/tlua_pkg.sv
rtl/tlua_if.sv
rtl/tlua_ram.sv
rtl/taint_label_union_allocator_top.sv
tb/sv/testbench.sv
